// File: rtl/cbc_pkg.sv
package cbc_pkg;

  localparam int unsigned ROM_BANKS      = 32;
  localparam int unsigned RAM_BANKS      = 4;
  localparam int unsigned ROM_BANK_BYTES = 16384;
  localparam int unsigned RAM_BANK_BYTES = 8192;

  localparam int unsigned ROM_DEPTH  = ROM_BANKS * ROM_BANK_BYTES;
  localparam int unsigned RAM_DEPTH  = RAM_BANKS * RAM_BANK_BYTES;
  localparam int unsigned ROM_ADDR_W = $clog2(ROM_DEPTH);
  localparam int unsigned RAM_ADDR_W = $clog2(RAM_DEPTH);
  localparam int unsigned ROM_OFS_W  = $clog2(ROM_BANK_BYTES);
  localparam int unsigned RAM_OFS_W  = $clog2(RAM_BANK_BYTES);
  localparam int unsigned ROM_BANK_W = ROM_ADDR_W - ROM_OFS_W;
  localparam int unsigned RAM_BANK_W = RAM_ADDR_W - RAM_OFS_W;

  localparam logic [2:0] ROM_LOG2_MAX = 3'd5;
  localparam logic [1:0] RAM_LOG2_MAX = 2'd2;
  localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;
  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

  // Upper three address bits select one 8 KiB region of the bus.
  localparam logic [2:0] REG_RAM_EN   = 3'b000;
  localparam logic [2:0] REG_ROM_BANK = 3'b001;
  localparam logic [2:0] REG_RAM_BANK = 3'b010;
  localparam logic [2:0] REG_MODE     = 3'b011;
  localparam logic [2:0] RAM_WINDOW   = 3'b101;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_LOAD  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_CART_KIND     = 2'd0,
    CFG_ROM_BANKS_LOG = 2'd1,
    CFG_RAM_PRESENT   = 2'd2,
    CFG_RAM_BANKS_LOG = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SRC_ROM = 2'd0,
    SRC_RAM = 2'd1,
    SRC_FF  = 2'd2
  } src_e;

  typedef struct packed {
    logic       cart_kind;
    logic [2:0] rom_banks_log2;
    logic       ram_present;
    logic [1:0] ram_banks_log2;
  } cfg_t;

  typedef struct packed {
    logic                  rom_re;
    logic                  rom_we;
    logic [ROM_ADDR_W-1:0] rom_addr;
    logic                  ram_re;
    logic                  ram_we;
    logic [RAM_ADDR_W-1:0] ram_addr;
    logic [7:0]            wdata;
    logic                  rd_accept;
    src_e                  src;
  } mem_req_t;

endpackage

// File: rtl/cbc_rom_mem.sv
module cbc_rom_mem (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic                           re_i,
  input  logic [cbc_pkg::ROM_ADDR_W-1:0] addr_i,
  input  logic [7:0]                     wdata_i,
  output logic [7:0]                     rdata_o
);

  logic [7:0] mem [cbc_pkg::ROM_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/cbc_ram_mem.sv
module cbc_ram_mem (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic                           re_i,
  input  logic [cbc_pkg::RAM_ADDR_W-1:0] addr_i,
  input  logic [7:0]                     wdata_i,
  output logic [7:0]                     rdata_o
);

  logic [7:0] mem [cbc_pkg::RAM_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/cbc_mapper.sv
module cbc_mapper (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [1:0]                     command_i,
  input  logic [15:0]                    bus_address_i,
  input  logic [7:0]                     write_byte_i,
  input  logic [cbc_pkg::ROM_ADDR_W-1:0] rom_load_address_i,
  input  cbc_pkg::cfg_t                  cfg_i,
  output cbc_pkg::mem_req_t              req_o
);

  logic [cbc_pkg::ROM_BANK_W-1:0] rom_bank_sel_q, rom_bank_sel_d;
  logic [1:0]                     ram_bank_sel_q, ram_bank_sel_d;
  logic                           adv_mode_q, adv_mode_d;
  logic                           ram_en_q, ram_en_d;

  logic [2:0]                     rom_lg;
  logic [1:0]                     ram_lg;
  logic [cbc_pkg::ROM_BANK_W-1:0] rom_mask, rom_bank_eff, rom_page;
  logic [cbc_pkg::RAM_BANK_W-1:0] ram_mask, ram_page;
  logic [2:0]                     region;
  logic                           is_read, is_write, is_load;
  logic                           rom_hit, ram_win, ram_open;
  logic [cbc_pkg::ROM_ADDR_W-1:0] rom_rd_addr;

  always_comb begin
    region   = bus_address_i[15:13];
    is_read  = accept_i && (command_i == cbc_pkg::CMD_READ);
    is_write = accept_i && (command_i == cbc_pkg::CMD_WRITE);
    is_load  = accept_i && (command_i == cbc_pkg::CMD_LOAD);

    rom_lg   = (cfg_i.rom_banks_log2 > cbc_pkg::ROM_LOG2_MAX) ? cbc_pkg::ROM_LOG2_MAX
                                                              : cfg_i.rom_banks_log2;
    ram_lg   = (cfg_i.ram_banks_log2 > cbc_pkg::RAM_LOG2_MAX) ? cbc_pkg::RAM_LOG2_MAX
                                                              : cfg_i.ram_banks_log2;
    rom_mask = cbc_pkg::ROM_BANK_W'(({{cbc_pkg::ROM_BANK_W{1'b0}}, 1'b1} << rom_lg) - 1'b1);
    ram_mask = cbc_pkg::RAM_BANK_W'(({{cbc_pkg::RAM_BANK_W{1'b0}}, 1'b1} << ram_lg) - 1'b1);
    rom_bank_eff = rom_bank_sel_q & rom_mask;

    // Plain kind maps the whole lower half linearly, so bit 14 is bank bit 0.
    if (cfg_i.cart_kind) begin
      rom_page = bus_address_i[14] ? rom_bank_eff : '0;
    end else begin
      rom_page = cbc_pkg::ROM_BANK_W'(bus_address_i[14]);
    end
    rom_rd_addr = {rom_page, bus_address_i[cbc_pkg::ROM_OFS_W-1:0]};

    ram_page = adv_mode_q ? (ram_bank_sel_q & ram_mask) : '0;
    rom_hit  = !bus_address_i[15];
    ram_win  = (region == cbc_pkg::RAM_WINDOW);
    ram_open = ram_en_q && cfg_i.ram_present;

    req_o.rom_we    = is_load;
    req_o.rom_re    = is_read && rom_hit;
    req_o.rom_addr  = is_load ? rom_load_address_i : rom_rd_addr;
    req_o.ram_addr  = {ram_page, bus_address_i[cbc_pkg::RAM_OFS_W-1:0]};
    req_o.ram_we    = is_write && ram_win && ram_open;
    req_o.ram_re    = is_read && ram_win && ram_open && cfg_i.cart_kind;
    req_o.wdata     = write_byte_i;
    req_o.rd_accept = is_read;
    if (rom_hit) begin
      req_o.src = cbc_pkg::SRC_ROM;
    end else if (ram_win && ram_open && cfg_i.cart_kind) begin
      req_o.src = cbc_pkg::SRC_RAM;
    end else begin
      req_o.src = cbc_pkg::SRC_FF;
    end

    rom_bank_sel_d = rom_bank_sel_q;
    ram_bank_sel_d = ram_bank_sel_q;
    adv_mode_d     = adv_mode_q;
    ram_en_d       = ram_en_q;
    if (is_write) begin
      unique case (region)
        cbc_pkg::REG_RAM_EN: begin
          ram_en_d = (write_byte_i[3:0] == cbc_pkg::RAM_ENABLE_KEY);
        end
        cbc_pkg::REG_ROM_BANK: begin
          if (cfg_i.cart_kind) begin
            rom_bank_sel_d = (write_byte_i[cbc_pkg::ROM_BANK_W-1:0] == '0) ?
                             cbc_pkg::ROM_BANK_W'(1) : write_byte_i[cbc_pkg::ROM_BANK_W-1:0];
          end
        end
        cbc_pkg::REG_RAM_BANK: ram_bank_sel_d = write_byte_i[1:0];
        cbc_pkg::REG_MODE:     adv_mode_d = write_byte_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_bank_sel_q <= cbc_pkg::ROM_BANK_W'(1);
      ram_bank_sel_q <= '0;
      adv_mode_q     <= 1'b0;
      ram_en_q       <= 1'b0;
    end else begin
      rom_bank_sel_q <= rom_bank_sel_d;
      ram_bank_sel_q <= ram_bank_sel_d;
      adv_mode_q     <= adv_mode_d;
      ram_en_q       <= ram_en_d;
    end
  end

  a_rom_bank_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rom_bank_sel_q != '0) else $error("ROM bank register holds zero");

  a_ram_we_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_o.ram_we |-> ram_en_q && cfg_i.ram_present)
    else $error("RAM written while closed");

  a_no_rom_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_o.rom_we && req_o.rom_re)) else $error("ROM read and load in one cycle");

endmodule

// File: rtl/cartridge_bank_controller_unit.sv
// Cartridge bank controller: maps CPU bus reads and writes onto a 512 KiB ROM store
// and a 32 KiB RAM store, plain or bank-switched as cart_kind selects. One beat is
// accepted every clock cycle, whatever the command, as long as the result side keeps
// up; with two reads held inside and the result stalled, the input stalls. A bus read
// returns its byte through the registered read port of the ROM or RAM and then the
// output register.
// Writes and ROM loads take effect at the edge that accepts them and produce no
// result beat; command 3 is dropped. The stores come out of reset undefined and get
// no clearing pass: load the ROM before reading it and write RAM before reading it.
// The configuration port is always ready; write it only while the block is idle.
module cartridge_bank_controller_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] bus_address_i,
  input  logic [7:0]  write_byte_i,
  input  logic [18:0] rom_load_address_i,
  // result beats
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_byte_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  cbc_pkg::cfg_t     cfg_q, cfg_d;
  cbc_pkg::mem_req_t req;
  cbc_pkg::src_e     s1_src_q, s1_src_d;
  logic              s1_valid_q, s1_valid_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic [7:0]        rom_rdata, ram_rdata, s1_byte;
  logic              accept, s1_adv;

  // Configuration registers: always ready, value masked to each register's width.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cbc_pkg::cfg_idx_e'(cfg_index_i))
        cbc_pkg::CFG_CART_KIND:     cfg_d.cart_kind      = cfg_data_i[0];
        cbc_pkg::CFG_ROM_BANKS_LOG: cfg_d.rom_banks_log2 = cfg_data_i[2:0];
        cbc_pkg::CFG_RAM_PRESENT:   cfg_d.ram_present    = cfg_data_i[0];
        cbc_pkg::CFG_RAM_BANKS_LOG: cfg_d.ram_banks_log2 = cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Stage one is the memory read register; it may only be overwritten once its
  // beat has moved into the output register. Stall the input side otherwise.
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  cbc_mapper u_mapper (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .command_i          (command_i),
    .bus_address_i      (bus_address_i),
    .write_byte_i       (write_byte_i),
    .rom_load_address_i (rom_load_address_i),
    .cfg_i              (cfg_q),
    .req_o              (req)
  );

  cbc_rom_mem u_rom (
    .clk_i   (clk_i),
    .we_i    (req.rom_we),
    .re_i    (req.rom_re),
    .addr_i  (req.rom_addr),
    .wdata_i (req.wdata),
    .rdata_o (rom_rdata)
  );

  cbc_ram_mem u_ram (
    .clk_i   (clk_i),
    .we_i    (req.ram_we),
    .re_i    (req.ram_re),
    .addr_i  (req.ram_addr),
    .wdata_i (req.wdata),
    .rdata_o (ram_rdata)
  );

  // Pick the byte for the beat in stage one; unmapped reads return 0xFF.
  always_comb begin
    unique case (s1_src_q)
      cbc_pkg::SRC_ROM: s1_byte = rom_rdata;
      cbc_pkg::SRC_RAM: s1_byte = ram_rdata;
      default:          s1_byte = cbc_pkg::UNMAPPED_BYTE;
    endcase
  end

  always_comb begin
    s1_valid_d  = s1_valid_q;
    s1_src_d    = s1_src_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    // drop the output beat once taken, then refill it from stage one
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (s1_adv) begin
      out_valid_d = 1'b1;
      out_byte_d  = s1_byte;
      s1_valid_d  = 1'b0;
    end
    // only reads occupy the pipe
    if (req.rd_accept) begin
      s1_valid_d = 1'b1;
      s1_src_d   = req.src;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cart_kind      <= 1'b1;
      cfg_q.rom_banks_log2 <= 3'd1;
      cfg_q.ram_present    <= 1'b0;
      cfg_q.ram_banks_log2 <= 2'd0;
      s1_valid_q           <= 1'b0;
      out_valid_q          <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_src_q   <= s1_src_d;
    out_byte_q <= out_byte_d;
  end

  assign out_valid_o = out_valid_q;
  assign read_byte_o = out_byte_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q) else $error("input stalled with room in pipe");

  a_read_enters_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.rd_accept |=> s1_valid_q) else $error("accepted read lost before stage one");

  a_stage_moves_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_valid_q |=> out_valid_q) else $error("result did not reach output");

endmodule

// File: sim/cbc_read_checker.sv
module cbc_read_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  command_i,
  input  logic [15:0] bus_address_i,
  input  logic [7:0]  write_byte_i,
  input  logic [18:0] rom_load_address_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  read_byte_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output int          fail_count_o,
  output int          reads_pending_o,
  output int          reads_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]    rom_image [cbc_pkg::ROM_DEPTH];
  logic [7:0]    ram_image [cbc_pkg::RAM_DEPTH];
  logic [4:0]    rom_bank_sel;
  logic [1:0]    ram_bank_sel;
  logic          advanced_mode;
  logic          ram_on;
  cbc_pkg::cfg_t setting;
  logic [7:0]    expected_bytes [$];

  function automatic logic [cbc_pkg::ROM_ADDR_W-1:0] rom_window_index(
      input logic [15:0] addr);
    logic [2:0] lg;
    logic [4:0] mask;
    lg = (setting.rom_banks_log2 > cbc_pkg::ROM_LOG2_MAX) ? cbc_pkg::ROM_LOG2_MAX
                                                         : setting.rom_banks_log2;
    mask = 5'((32'd1 << lg) - 32'd1);
    return {rom_bank_sel & mask, addr[13:0]};
  endfunction

  // Simple mode always maps bank 0 into the RAM window.
  function automatic logic [cbc_pkg::RAM_ADDR_W-1:0] ram_window_index(
      input logic [15:0] addr);
    logic [1:0] lg;
    logic [1:0] bank;
    bank = 2'd0;
    if (advanced_mode) begin
      lg = (setting.ram_banks_log2 > cbc_pkg::RAM_LOG2_MAX) ? cbc_pkg::RAM_LOG2_MAX
                                                           : setting.ram_banks_log2;
      bank = ram_bank_sel & 2'((32'd1 << lg) - 32'd1);
    end
    return {bank, addr[12:0]};
  endfunction

  function automatic logic [7:0] decode_read(input logic [15:0] addr);
    if (!setting.cart_kind) begin
      return addr[15] ? cbc_pkg::UNMAPPED_BYTE
                      : rom_image[cbc_pkg::ROM_ADDR_W'(addr[14:0])];
    end
    if (addr[15:14] == 2'b00) begin
      return rom_image[cbc_pkg::ROM_ADDR_W'(addr[13:0])];
    end
    if (addr[15:14] == 2'b01) begin
      return rom_image[rom_window_index(addr)];
    end
    if (addr[15:13] == cbc_pkg::RAM_WINDOW && ram_on && setting.ram_present) begin
      return ram_image[ram_window_index(addr)];
    end
    return cbc_pkg::UNMAPPED_BYTE;
  endfunction

  function automatic void apply_bus_write(input logic [15:0] addr, input logic [7:0] data);
    case (addr[15:13])
      cbc_pkg::REG_RAM_EN:   ram_on = (data[3:0] == cbc_pkg::RAM_ENABLE_KEY);
      cbc_pkg::REG_ROM_BANK: begin
        if (setting.cart_kind) begin
          rom_bank_sel = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
        end
      end
      cbc_pkg::REG_RAM_BANK: ram_bank_sel = data[1:0];
      cbc_pkg::REG_MODE:     advanced_mode = data[0];
      cbc_pkg::RAM_WINDOW: begin
        if (ram_on && setting.ram_present) begin
          ram_image[ram_window_index(addr)] = data;
        end
      end
      default: ;
    endcase
  endfunction

  // Compare the result beat first: it always belongs to an older read.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [7:0] want;
    if (!rst_ni) begin
      rom_bank_sel           = 5'd1;
      ram_bank_sel           = 2'd0;
      advanced_mode          = 1'b0;
      ram_on                 = 1'b0;
      setting.cart_kind      = 1'b1;
      setting.rom_banks_log2 = 3'd1;
      setting.ram_present    = 1'b0;
      setting.ram_banks_log2 = 2'd0;
      expected_bytes.delete();
      fail_count_o           = 0;
      reads_checked_o        = 0;
      reads_pending_o        = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          $error("read_byte: result beat with no read outstanding, actual %02h", read_byte_i);
          fail_count_o++;
        end else begin
          want = expected_bytes.pop_front();
          reads_checked_o++;
          if (read_byte_i !== want) begin
            $error("read_byte: expected %02h, actual %02h", want, read_byte_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          cbc_pkg::CFG_CART_KIND:     setting.cart_kind = cfg_data_i[0];
          cbc_pkg::CFG_ROM_BANKS_LOG: setting.rom_banks_log2 = cfg_data_i[2:0];
          cbc_pkg::CFG_RAM_PRESENT:   setting.ram_present = cfg_data_i[0];
          cbc_pkg::CFG_RAM_BANKS_LOG: setting.ram_banks_log2 = cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        case (command_i)
          cbc_pkg::CMD_READ:  expected_bytes.push_back(decode_read(bus_address_i));
          cbc_pkg::CMD_WRITE: apply_bus_write(bus_address_i, write_byte_i);
          cbc_pkg::CMD_LOAD:  rom_image[rom_load_address_i] = write_byte_i;
          default: ;
        endcase
      end
      reads_pending_o = expected_bytes.size();
    end
  end

endmodule

// File: sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Command code 3 has no meaning; the block must drop it without a result.
  localparam logic [1:0] CMD_NONE = 2'd3;

  localparam int RANDOM_BEATS    = 650;
  localparam int PHASES          = 10;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 6;
  localparam int PRESSURE_PHASE  = 2;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  command_i;
  logic [15:0] bus_address_i;
  logic [7:0]  write_byte_i;
  logic [18:0] rom_load_address_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  read_byte_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;

  int fail_count;
  int reads_pending;
  int reads_checked;
  int beats_sent;

  // quiet_phase switches idling off on both sides for a whole phase;
  // hold_off_pending asks the result side for one long stall.
  bit quiet_phase;
  bit hold_off_pending;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  cartridge_bank_controller_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .bus_address_i      (bus_address_i),
    .write_byte_i       (write_byte_i),
    .rom_load_address_i (rom_load_address_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .read_byte_o        (read_byte_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  cbc_read_checker checker_inst (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .command_i          (command_i),
    .bus_address_i      (bus_address_i),
    .write_byte_i       (write_byte_i),
    .rom_load_address_i (rom_load_address_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .read_byte_i        (read_byte_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .fail_count_o       (fail_count),
    .reads_pending_o    (reads_pending),
    .reads_checked_o    (reads_checked)
  );

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet_phase) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end
    if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 40);
  endfunction

  // Offsets that are stocked in every ROM and RAM bank before any read: the low
  // eight bytes and the top eight bytes of the bank. Reads only ever use these,
  // so no read can land on a store entry that was never written.
  function automatic logic [13:0] stocked_offset(input logic [3:0] slot, input bit ram_side);
    if (!slot[3]) begin
      return 14'(slot[2:0]);
    end
    return (ram_side ? 14'h1FF8 : 14'h3FF8) | 14'(slot[2:0]);
  endfunction

  // Result side: random stalls, plus the one long hold-off that backs the
  // block up until it stalls its input.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (quiet_phase) begin
        stall_left = 0;
        out_stall_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_stall_i <= (stall_left != 0);
        if (stall_left != 0) begin
          stall_left--;
        end
      end
    end
  end

  // Offer one beat after a random gap and hold it until it is taken. Return at
  // the accepting edge; the next call drops valid or changes the payload at the next falling edge.
  task automatic send_beat(input logic [1:0] cmd, input logic [15:0] addr,
                           input logic [7:0] data, input logic [18:0] load_addr);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    command_i          <= cmd;
    bus_address_i      <= addr;
    write_byte_i       <= data;
    rom_load_address_i <= load_addr;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
  endtask

  // Unused fields carry noise so the block is seen to ignore them.
  task automatic read_at(input logic [15:0] addr);
    send_beat(cbc_pkg::CMD_READ, addr, 8'($urandom), 19'($urandom));
  endtask

  task automatic write_at(input logic [15:0] addr, input logic [7:0] data);
    send_beat(cbc_pkg::CMD_WRITE, addr, data, 19'($urandom));
  endtask

  task automatic load_rom(input logic [18:0] load_addr, input logic [7:0] data);
    send_beat(cbc_pkg::CMD_LOAD, 16'($urandom), data, load_addr);
  endtask

  // Drop valid, let every outstanding read come back, then wait out SETTLE_CYCLES
  // so trailing writes and loads have settled.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (reads_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input cbc_pkg::cfg_idx_e idx, input logic [7:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Write all four registers; the unused upper data bits carry noise.
  task automatic program_setting(input logic kind, input logic [2:0] rom_log,
                                 input logic ram_fitted, input logic [1:0] ram_log);
    logic [7:0] noise;
    noise = $urandom;
    write_register(cbc_pkg::CFG_CART_KIND, {noise[7:1], kind});
    noise = $urandom;
    write_register(cbc_pkg::CFG_ROM_BANKS_LOG, {noise[7:3], rom_log});
    noise = $urandom;
    write_register(cbc_pkg::CFG_RAM_PRESENT, {noise[7:1], ram_fitted});
    noise = $urandom;
    write_register(cbc_pkg::CFG_RAM_BANKS_LOG, {noise[7:2], ram_log});
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One random beat: reads of stocked locations and of unmapped space, register
  // and RAM writes, ROM loads and the odd meaningless command.
  task automatic random_beat();
    int unsigned roll;
    int unsigned region;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [13:0] ofs;
    roll   = $urandom_range(0, 99);
    region = $urandom_range(0, 5);
    addr   = 16'($urandom);
    data   = 8'($urandom);
    if (roll < 42) begin
      ofs = stocked_offset(4'($urandom), region == 2);
      case (region)
        0: addr = {2'b00, ofs};
        1, 3: addr = {2'b01, ofs};
        2: addr = {cbc_pkg::RAM_WINDOW, ofs[12:0]};
        default: begin
          // unmapped space: keep out of the ROM halves and the RAM window
          addr[15] = 1'b1;
          if (addr[15:13] == cbc_pkg::RAM_WINDOW) begin
            addr[14] = 1'b1;
          end
        end
      endcase
      read_at(addr);
    end else if (roll < 76) begin
      if (region < 4) begin
        addr[15:13] = 3'(region);
      end else if (region == 4) begin
        addr[15:13] = cbc_pkg::RAM_WINDOW;
      end
      // favour the enabling key so RAM is open most of the time
      if (addr[15:13] == cbc_pkg::REG_RAM_EN && $urandom_range(0, 2) != 0) begin
        data[3:0] = cbc_pkg::RAM_ENABLE_KEY;
      end
      write_at(addr, data);
    end else if (roll < 94) begin
      if (region < 3) begin
        load_rom({5'($urandom), stocked_offset(4'($urandom), 1'b0)}, data);
      end else begin
        load_rom(19'($urandom), data);
      end
    end else begin
      send_beat(CMD_NONE, addr, data, 19'($urandom));
    end
  endtask

  initial begin
    in_valid_i         = 1'b0;
    command_i          = cbc_pkg::CMD_READ;
    bus_address_i      = 16'h0000;
    write_byte_i       = 8'h00;
    rom_load_address_i = 19'h00000;
    out_stall_i        = 1'b0;
    cfg_valid_i        = 1'b0;
    cfg_index_i        = cbc_pkg::CFG_CART_KIND;
    cfg_data_i         = 8'h00;
    quiet_phase        = 1'b0;
    hold_off_pending   = 1'b0;
    beats_sent         = 0;
    rst_ni             = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Widest setting first, so every ROM and RAM bank can be stocked.
    program_setting(1'b1, 3'd5, 1'b1, 2'd2);
    for (int bank = 0; bank < cbc_pkg::ROM_BANKS; bank++) begin
      for (int slot = 0; slot < 16; slot++) begin
        load_rom({5'(bank), stocked_offset(4'(slot), 1'b0)}, 8'($urandom));
      end
    end
    // open RAM in advanced mode and stock each RAM bank in turn
    write_at(16'h0000, 8'h0A);
    write_at(16'h6000, 8'h01);
    for (int bank = 0; bank < cbc_pkg::RAM_BANKS; bank++) begin
      write_at(16'h4000, 8'(bank));
      for (int slot = 0; slot < 16; slot++) begin
        write_at({cbc_pkg::RAM_WINDOW, 13'(stocked_offset(4'(slot), 1'b1))},
                 8'($urandom));
      end
    end

    // Directed beats: window edges, bank 0 turned into bank 1, full bank
    // number, RAM enable and disable, both banking modes, unmapped reads,
    // loads at both ends of the ROM store and the meaningless command.
    read_at(16'h0000);
    read_at(16'h3FFF);
    write_at(16'h2000, 8'h00);
    read_at(16'h4000);
    write_at(16'h3FFF, 8'hFF);
    read_at(16'h7FFF);
    write_at(16'h6000, 8'h01);
    write_at(16'h4000, 8'h02);
    write_at(16'h0000, 8'h0A);
    write_at(16'hBFFF, 8'hA5);
    read_at(16'hBFFF);
    read_at(16'hA000);
    write_at(16'h6000, 8'hFE);
    read_at(16'hA007);
    write_at(16'h1FFF, 8'h1B);
    read_at(16'hA000);
    write_at(16'hA000, 8'h33);
    read_at(16'h8000);
    read_at(16'hFFFF);
    read_at(16'hC000);
    load_rom(19'h7FFFF, 8'hFF);
    read_at(16'h7FFF);
    load_rom(19'h00000, 8'h00);
    read_at(16'h0000);
    send_beat(CMD_NONE, 16'hFFFF, 8'hFF, 19'h7FFFF);
    write_at(16'h9FFF, 8'hFF);

    // Random phases, one register setting each: widest, zero and oversized
    // log2 values, plain ROM, no RAM, three mixed ones, then two drawn at random.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0: program_setting(1'b1, 3'd5, 1'b1, 2'd2);
        1: program_setting(1'b1, 3'd0, 1'b1, 2'd0);
        2: program_setting(1'b1, 3'd7, 1'b1, 2'd3);
        3: program_setting(1'b0, 3'd5, 1'b1, 2'd2);
        4: program_setting(1'b1, 3'd1, 1'b0, 2'd1);
        5: program_setting(1'b1, 3'd6, 1'b1, 2'd1);
        6: program_setting(1'b0, 3'd0, 1'b0, 2'd0);
        7: program_setting(1'b1, 3'd3, 1'b1, 2'd3);
        default: program_setting(1'($urandom), 3'($urandom), 1'($urandom), 2'($urandom));
      endcase
      // no idling in some phases, so back-to-back beats are covered too
      quiet_phase = (phase == 3 || phase == 7);
      if (phase == PRESSURE_PHASE) begin
        hold_off_pending = 1'b1;
      end
      repeat (RANDOM_BEATS / PHASES) random_beat();
    end

    drain_results();
    $display("covered %0d input beats across %0d register settings, with a long result stall",
             beats_sent, PHASES + 1);
    $display("compared %0d read bytes from ROM, RAM and unmapped space", reads_checked);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
